FILE: rtl/sprd_pkg.sv
// ----------------------------------------------------------------------------
// sprd_pkg
// Shared types and constants for the sprite run-length decoder.
// ----------------------------------------------------------------------------
package sprd_pkg;

  localparam int MAX_DIM   = 1024;
  localparam int TILE_SIZE = 64;

  localparam int CFG_DIM_W = 11;                            // register field width
  localparam int DIM_W     = $clog2(MAX_DIM + 1);           // clamped dimension
  localparam int ADDR_W    = 20;
  localparam int CAP_W     = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int TILE_W    = $clog2(TILE_SIZE);
  localparam int TCOL_W    = $clog2(MAX_DIM / TILE_SIZE);
  localparam int PEND_W    = 17;
  localparam int PADDR_W   = 4;

  localparam logic [31:0] RUN_MARK  = 32'hFF00_0000;
  localparam int          LIT_COUNT = 4;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TILED  = 2'd2;

  typedef enum logic {
    REQ_WORD = 1'b0,
    REQ_TICK = 1'b1
  } req_type_t;

  typedef struct packed {
    req_type_t   req_type;
    logic [31:0] data_word;
    logic        final_word;
  } in_item_t;

  typedef struct packed {
    logic              pixel_valid;
    logic [7:0]        pixel_value;
    logic [ADDR_W-1:0] pixel_address;
    logic              sprite_done;
    logic              word_dropped;
    logic              ready_for_word;
  } out_item_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             tiled;
    logic [CAP_W-1:0] cap;
    logic             clear;
  } sprd_cfg_t;

endpackage

FILE: rtl/sprd_cfg.sv
// ----------------------------------------------------------------------------
// sprd_cfg
// APB register file: sprite size and mode, clamped size and capacity.
// ----------------------------------------------------------------------------
module sprd_cfg
  import sprd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  output sprd_cfg_t          cfg
);

  logic [CFG_DIM_W-1:0] width_r;
  logic [CFG_DIM_W-1:0] height_r;
  logic                 tiled_r;
  logic [CAP_W-1:0]     cap_r;
  logic [1:0]           idx;
  logic                 wr;
  logic                 hit;
  logic [DIM_W-1:0]     w_c;
  logic [DIM_W-1:0]     h_c;

  assign cfg_pready = 1'b1;
  assign idx = cfg_paddr[3:2];
  assign wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign hit = (idx == REG_WIDTH) || (idx == REG_HEIGHT) || (idx == REG_TILED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_DIM_W'(64);
      height_r <= CFG_DIM_W'(64);
      tiled_r  <= 1'b0;
    end else if (wr) begin
      case (idx)
        REG_WIDTH:  width_r  <= cfg_pwdata[CFG_DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_pwdata[CFG_DIM_W-1:0];
        REG_TILED:  tiled_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WIDTH:  cfg_prdata = 32'(width_r);
      REG_HEIGHT: cfg_prdata = 32'(height_r);
      REG_TILED:  cfg_prdata = 32'(tiled_r);
      default:    cfg_prdata = 32'd0;
    endcase
  end

  // zero acts as one, oversize saturates
  always_comb begin
    if (width_r == '0)                          w_c = DIM_W'(1);
    else if (width_r > CFG_DIM_W'(MAX_DIM))     w_c = DIM_W'(MAX_DIM);
    else                                        w_c = DIM_W'(width_r);
    if (height_r == '0)                         h_c = DIM_W'(1);
    else if (height_r > CFG_DIM_W'(MAX_DIM))    h_c = DIM_W'(MAX_DIM);
    else                                        h_c = DIM_W'(height_r);
  end

  // capacity is registered from the clamped size, settled before the first pixel
  always_ff @(posedge clk) begin
    cap_r <= CAP_W'(w_c) * CAP_W'(h_c);
  end

  assign cfg.width  = w_c;
  assign cfg.height = h_c;
  assign cfg.tiled  = tiled_r;
  assign cfg.cap    = cap_r;
  assign cfg.clear  = wr && hit;

endmodule

FILE: rtl/sprd_tile_addr.sv
// ----------------------------------------------------------------------------
// sprd_tile_addr
// Tiled-order position walker: gives the row-major address of the current
// pixel and steps to the next one, clipping edge tiles.
// ----------------------------------------------------------------------------
module sprd_tile_addr
  import sprd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear,
  input  logic              step,
  input  logic [DIM_W-1:0]  width,
  input  logic [DIM_W-1:0]  height,
  output logic [ADDR_W-1:0] addr
);

  logic [TCOL_W-1:0] tile_col_r, tile_col_nxt;
  logic [TCOL_W-1:0] tile_row_r, tile_row_nxt;
  logic [TILE_W-1:0] inner_x_r, inner_x_nxt;
  logic [TILE_W-1:0] inner_y_r, inner_y_nxt;
  logic [ADDR_W-1:0] row_base_r, row_base_nxt;
  logic [ADDR_W-1:0] trow_base_r, trow_base_nxt;   // tile_row * TILE_SIZE * width

  logic [DIM_W-1:0]  bx, by, tw_raw, th_raw, tw, th, ix_inc, iy_inc, col_edge;
  logic [TCOL_W:0]   col_inc;

  always_comb begin
    bx      = DIM_W'({tile_col_r, {TILE_W{1'b0}}});
    by      = DIM_W'({tile_row_r, {TILE_W{1'b0}}});
    tw_raw  = (width  > bx) ? width  - bx : DIM_W'(1);
    th_raw  = (height > by) ? height - by : DIM_W'(1);
    tw      = (tw_raw > DIM_W'(TILE_SIZE)) ? DIM_W'(TILE_SIZE) : tw_raw;
    th      = (th_raw > DIM_W'(TILE_SIZE)) ? DIM_W'(TILE_SIZE) : th_raw;
    ix_inc  = DIM_W'(inner_x_r) + DIM_W'(1);
    iy_inc  = DIM_W'(inner_y_r) + DIM_W'(1);
    col_inc = {1'b0, tile_col_r} + (TCOL_W+1)'(1);
    col_edge = DIM_W'({col_inc, {TILE_W{1'b0}}});
    addr    = row_base_r + ADDR_W'(bx) + ADDR_W'(inner_x_r);

    tile_col_nxt  = tile_col_r;
    tile_row_nxt  = tile_row_r;
    inner_x_nxt   = inner_x_r;
    inner_y_nxt   = inner_y_r;
    row_base_nxt  = row_base_r;
    trow_base_nxt = trow_base_r;

    if (step) begin
      if (ix_inc >= tw) begin
        inner_x_nxt = '0;
        if (iy_inc >= th) begin
          inner_y_nxt = '0;
          if (col_edge >= width) begin
            tile_col_nxt  = '0;
            tile_row_nxt  = tile_row_r + TCOL_W'(1);
            trow_base_nxt = trow_base_r + ADDR_W'({width, {TILE_W{1'b0}}});
            row_base_nxt  = trow_base_nxt;
          end else begin
            tile_col_nxt = col_inc[TCOL_W-1:0];
            row_base_nxt = trow_base_r;
          end
        end else begin
          inner_y_nxt  = TILE_W'(iy_inc);
          row_base_nxt = row_base_r + ADDR_W'(width);
        end
      end else begin
        inner_x_nxt = TILE_W'(ix_inc);
      end
    end

    if (clear) begin
      tile_col_nxt  = '0;
      tile_row_nxt  = '0;
      inner_x_nxt   = '0;
      inner_y_nxt   = '0;
      row_base_nxt  = '0;
      trow_base_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_col_r  <= '0;
      tile_row_r  <= '0;
      inner_x_r   <= '0;
      inner_y_r   <= '0;
      row_base_r  <= '0;
      trow_base_r <= '0;
    end else begin
      tile_col_r  <= tile_col_nxt;
      tile_row_r  <= tile_row_nxt;
      inner_x_r   <= inner_x_nxt;
      inner_y_r   <= inner_y_nxt;
      row_base_r  <= row_base_nxt;
      trow_base_r <= trow_base_nxt;
    end
  end

endmodule

FILE: rtl/sprite_rle_detile_decoder.sv
// ----------------------------------------------------------------------------
// sprite_rle_detile_decoder
// Run-length sprite decoder: words in, up to one addressed pixel per tick out.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register.
// Throughput: one item per cycle while out_stall is low; decode state and
//   tile walker update once per item in the stage between the two registers.
// Reset: rst_n synchronous, active low; restores 64x64 linear mode and clears
//   all decode, position and discard state but the run pixel and literal data.
// A width, height or tiled write aborts the current sprite the same way.
// ----------------------------------------------------------------------------
module sprite_rle_detile_decoder
  import sprd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // item input
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_item,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_item,
  // configuration
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  sprd_cfg_t cfg;

  sprd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // --------------------------------------------------------------------------
  // Input register. Holds one item; it moves on whenever the result register
  // is free or being drained this cycle, so the stream runs at full rate.
  // --------------------------------------------------------------------------
  in_item_t item_r;
  logic     item_vld_r, item_vld_nxt;
  logic     fire;
  logic     in_take;

  assign fire     = item_vld_r && (!out_valid || !out_stall);
  assign in_stall = item_vld_r && !fire;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    if (in_take)   item_vld_nxt = 1'b1;
    else if (fire) item_vld_nxt = 1'b0;
    else           item_vld_nxt = item_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) item_vld_r <= 1'b0;
    else        item_vld_r <= item_vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_take) item_r <= in_item;
  end

  // --------------------------------------------------------------------------
  // Decode state
  // --------------------------------------------------------------------------
  logic [PEND_W-1:0] pending_r, pending_nxt;
  logic [7:0]        run_pixel_r, run_pixel_nxt;
  logic [31:0]       literal_r, literal_nxt;
  logic              lit_active_r, lit_active_nxt;
  logic [ADDR_W-1:0] emitted_r, emitted_nxt;
  logic              discarding_r, discarding_nxt;
  logic              final_seen_r, final_seen_nxt;

  logic [CAP_W-1:0]  emitted_inc;
  logic [ADDR_W-1:0] tile_addr;
  logic              tile_step;
  logic              sprite_clear;
  logic              pend_zero;
  out_item_t         res;

  sprd_tile_addr u_tile (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  (sprite_clear || cfg.clear),
    .step   (tile_step),
    .width  (cfg.width),
    .height (cfg.height),
    .addr   (tile_addr)
  );

  always_comb begin
    pending_nxt    = pending_r;
    run_pixel_nxt  = run_pixel_r;
    literal_nxt    = literal_r;
    lit_active_nxt = lit_active_r;
    emitted_nxt    = emitted_r;
    discarding_nxt = discarding_r;
    final_seen_nxt = final_seen_r;
    emitted_inc    = CAP_W'(emitted_r) + CAP_W'(1);
    pend_zero      = (pending_r == '0);
    tile_step      = 1'b0;
    sprite_clear   = 1'b0;
    res            = '0;

    if (fire) begin
      case (item_r.req_type)
        REQ_WORD: begin
          if (!pend_zero) begin
            // pixels still owed: word is lost, its final mark too
            res.word_dropped = 1'b1;
          end else if (discarding_r) begin
            // overflowed sprite: skip until its final word
            res.word_dropped = 1'b1;
            if (item_r.final_word) discarding_nxt = 1'b0;
          end else begin
            if ((item_r.data_word & RUN_MARK) == RUN_MARK) begin
              pending_nxt    = PEND_W'(item_r.data_word[15:0]);
              run_pixel_nxt  = item_r.data_word[23:16];
              lit_active_nxt = 1'b0;
            end else begin
              pending_nxt    = PEND_W'(LIT_COUNT);
              literal_nxt    = item_r.data_word;
              lit_active_nxt = 1'b1;
            end
            final_seen_nxt = item_r.final_word;
            // final run of zero length ends the sprite at once
            if (item_r.final_word && pending_nxt == '0) begin
              res.sprite_done = 1'b1;
              sprite_clear    = 1'b1;
            end
          end
        end
        REQ_TICK: begin
          if (!pend_zero) begin
            res.pixel_valid = 1'b1;
            if (lit_active_r) begin
              res.pixel_value = literal_r[7:0];
              literal_nxt     = {8'd0, literal_r[31:8]};
            end else begin
              res.pixel_value = run_pixel_r;
            end
            tile_step         = cfg.tiled;
            res.pixel_address = cfg.tiled ? tile_addr : emitted_r;
            pending_nxt       = pending_r - PEND_W'(1);
            emitted_nxt       = ADDR_W'(emitted_inc);
            if (emitted_inc >= cfg.cap) begin
              // capacity hit: drop the rest of the stream unless it ended
              res.sprite_done = 1'b1;
              sprite_clear    = 1'b1;
              discarding_nxt  = !final_seen_r;
            end else if (pending_nxt == '0 && final_seen_r) begin
              res.sprite_done = 1'b1;
              sprite_clear    = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    if (sprite_clear) begin
      pending_nxt    = '0;
      lit_active_nxt = 1'b0;
      emitted_nxt    = '0;
      final_seen_nxt = 1'b0;
    end

    res.ready_for_word = (pending_nxt == '0);

    if (cfg.clear) begin
      pending_nxt    = '0;
      lit_active_nxt = 1'b0;
      emitted_nxt    = '0;
      final_seen_nxt = 1'b0;
      discarding_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r    <= '0;
      lit_active_r <= 1'b0;
      emitted_r    <= '0;
      discarding_r <= 1'b0;
      final_seen_r <= 1'b0;
    end else begin
      pending_r    <= pending_nxt;
      lit_active_r <= lit_active_nxt;
      emitted_r    <= emitted_nxt;
      discarding_r <= discarding_nxt;
      final_seen_r <= final_seen_nxt;
    end
  end

  // run pixel and literal bytes are only read after a word reloads them
  always_ff @(posedge clk) begin
    run_pixel_r <= run_pixel_nxt;
    literal_r   <= literal_nxt;
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  always_comb begin
    if (fire)                   out_valid_nxt = 1'b1;
    else if (!out_stall)        out_valid_nxt = 1'b0;
    else                        out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (fire) out_item_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
